// ===== rtl/rfir_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the ring FIFO with indexed read.
package rfir_pkg;

  localparam int DepthDefault = 1024;
  localparam int CapRegW      = 11;
  localparam int CapResetVal  = 1024;
  localparam int WordW        = 32;

  typedef enum logic [2:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_PEEK     = 3'd2,
    CMD_READ_OLD = 3'd3,
    CMD_READ_NEW = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [WordW-1:0]   push_value;
    logic [CapRegW-1:0] index;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0]   read_value;
    logic [1:0]         status;
    logic [CapRegW-1:0] count;
    logic               is_full;
    logic               is_empty;
  } rsp_t;

endpackage

// ===== rtl/ring_fifo_indexed_read_unit.sv =====
`timescale 1ns / 1ps
// Ring FIFO of 32-bit words with push, pop, peek and indexed reads.
// Flow: a request is registered on acceptance, executed in S_EXEC and answered from
// S_RESP once the output is free; a new request is taken only back in S_IDLE, so requests
// do not overlap. The entry memory is single-port with registered read data.
// Reset: pointers zero, queue empty, capacity min(1024, DEPTH); the entry
// memory is not cleared and needs no clearing pass.
module ring_fifo_indexed_read_unit #(
  parameter int DEPTH = rfir_pkg::DepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rfir_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rfir_pkg::rsp_t out_rsp_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int CmpW  = (CntW > rfir_pkg::CapRegW) ? CntW : rfir_pkg::CapRegW;
  localparam int CmpW1 = CmpW + 1;
  localparam int CntW1 = CntW + 1;
  localparam int CapResetI = (DEPTH < rfir_pkg::CapResetVal) ? DEPTH : rfir_pkg::CapResetVal;
  localparam logic [CntW-1:0] CapReset = CntW'(CapResetI);
  localparam logic [CmpW:0]   DepthC   = CmpW1'(DEPTH);

  rfir_pkg::state_e state_q, state_d;
  rfir_pkg::req_t   req_q;
  logic [PtrW-1:0]  rp_q, rp_d, wp_q, wp_d;
  logic             empty_q, empty_d;
  logic [CntW-1:0]  cap_q;
  logic [1:0]       st_q, st_d;
  logic             hit_q, hit_d;
  logic             out_valid_q, out_valid_d;
  rfir_pkg::rsp_t   out_rsp_q, out_rsp_d;

  logic [rfir_pkg::WordW-1:0] mem [DEPTH];
  logic [rfir_pkg::WordW-1:0] rdata_q;
  logic                       mem_we, mem_re;
  logic [PtrW-1:0]            mem_addr;

  logic            cfg_wr;
  logic [CmpW:0]   cfg_val;
  logic [CntW-1:0] cap_new;

  logic [CntW:0]   cnt_wide;
  logic [CntW-1:0] cnt_cur;
  logic            full_cur;
  logic            idx_ge;
  logic [CmpW:0]   old_sum, old_adj, new_diff, new_adj;
  logic [PtrW-1:0] rp_next, wp_next;
  logic            out_free;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p,
                                                input logic [CntW-1:0] cap);
    logic [CntW:0] n;
    n = CntW1'(p) + CntW1'(1);
    return (n >= CntW1'(cap)) ? '0 : PtrW'(n);
  endfunction

  // Configuration port: one register, capacity, clamped to 1..DEPTH.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && !paddr[2];
  assign cfg_val = CmpW1'(pwdata[rfir_pkg::CapRegW-1:0]);
  assign prdata  = paddr[2] ? 32'd0 : 32'(cap_q);

  always_comb begin
    if (cfg_val == '0) begin
      cap_new = CntW'(1);
    end else if (cfg_val > DepthC) begin
      cap_new = CntW'(DEPTH);
    end else begin
      cap_new = CntW'(cfg_val);
    end
  end

  // Occupancy from the current pointers; pre-state in S_EXEC, post-state in S_RESP.
  always_comb begin
    if (empty_q) begin
      cnt_wide = '0;
    end else if (wp_q <= rp_q) begin
      cnt_wide = CntW1'(wp_q) + CntW1'(cap_q) - CntW1'(rp_q);
    end else begin
      cnt_wide = CntW1'(wp_q) - CntW1'(rp_q);
    end
  end
  assign cnt_cur  = CntW'(cnt_wide);
  assign full_cur = !empty_q && (rp_q == wp_q);
  assign idx_ge   = CmpW1'(req_q.index) >= CmpW1'(cnt_cur);

  // Indexed addresses stay below twice the capacity: one conditional subtract or add.
  always_comb begin
    old_sum  = CmpW1'(rp_q) + CmpW1'(req_q.index);
    old_adj  = (old_sum >= CmpW1'(cap_q)) ? old_sum - CmpW1'(cap_q) : old_sum;
    new_diff = CmpW1'(wp_q) - CmpW1'(req_q.index) - CmpW1'(1);
    new_adj  = new_diff[CmpW] ? new_diff + CmpW1'(cap_q) : new_diff;
  end

  assign rp_next  = next_slot(rp_q, cap_q);
  assign wp_next  = next_slot(wp_q, cap_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfir_pkg::S_IDLE: if (in_valid_i) state_d = rfir_pkg::S_EXEC;
      rfir_pkg::S_EXEC: state_d = rfir_pkg::S_RESP;
      rfir_pkg::S_RESP: if (out_free) state_d = rfir_pkg::S_IDLE;
      default:          state_d = rfir_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    in_stall_o  = (state_q != rfir_pkg::S_IDLE);
    rp_d        = rp_q;
    wp_d        = wp_q;
    empty_d     = empty_q;
    st_d        = st_q;
    hit_d       = hit_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = rp_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;

    if (state_q == rfir_pkg::S_EXEC) begin
      st_d  = rfir_pkg::ST_OK;
      hit_d = 1'b0;
      unique case (req_q.command)
        rfir_pkg::CMD_PUSH: begin
          if (full_cur) begin
            st_d = rfir_pkg::ST_OVERFLOW;
          end else begin
            mem_we   = 1'b1;
            mem_addr = wp_q;
            if (empty_q) rp_d = wp_q;
            empty_d  = 1'b0;
            wp_d     = wp_next;
          end
        end
        rfir_pkg::CMD_POP, rfir_pkg::CMD_PEEK: begin
          if (empty_q) begin
            st_d = rfir_pkg::ST_UNDERFLOW;
          end else begin
            mem_re   = 1'b1;
            hit_d    = 1'b1;
            mem_addr = rp_q;
            if (req_q.command == rfir_pkg::CMD_POP) begin
              rp_d    = rp_next;
              empty_d = (rp_next == wp_q);
            end
          end
        end
        rfir_pkg::CMD_READ_OLD, rfir_pkg::CMD_READ_NEW: begin
          if (idx_ge) begin
            st_d = rfir_pkg::ST_RANGE;
          end else begin
            mem_re   = 1'b1;
            hit_d    = 1'b1;
            mem_addr = (req_q.command == rfir_pkg::CMD_READ_OLD) ? PtrW'(old_adj)
                                                                 : PtrW'(new_adj);
          end
        end
        default: ;
      endcase
    end

    if (state_q == rfir_pkg::S_RESP && out_free) begin
      out_valid_d          = 1'b1;
      out_rsp_d.read_value = hit_q ? rdata_q : '0;
      out_rsp_d.status     = st_q;
      out_rsp_d.count      = rfir_pkg::CapRegW'(cnt_cur);
      out_rsp_d.is_full    = full_cur;
      out_rsp_d.is_empty   = empty_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rfir_pkg::S_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      empty_q     <= 1'b1;
      cap_q       <= CapReset;
      st_q        <= rfir_pkg::ST_OK;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        cap_q   <= cap_new;
        rp_q    <= '0;
        wp_q    <= '0;
        empty_q <= 1'b1;
      end else begin
        rp_q    <= rp_d;
        wp_q    <= wp_d;
        empty_q <= empty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rfir_pkg::S_IDLE && in_valid_i) begin
      req_q <= in_req_i;
    end
    out_rsp_q <= out_rsp_d;
  end

  // Entry memory: one access per cycle, registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= req_q.push_value;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntW1'(rp_q) < CntW1'(cap_q)) && (CntW1'(wp_q) < CntW1'(cap_q)))
    else $error("pointer at or beyond capacity");

  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CmpW1'(out_rsp_o.count) <= CmpW1'(cap_q)))
    else $error("count exceeds capacity");

  a_full_empty_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.is_full && out_rsp_o.is_empty))
    else $error("full and empty together");

  a_error_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status != rfir_pkg::ST_OK) |-> (out_rsp_o.read_value == '0))
    else $error("error response carries data");

endmodule
